// ===== hdl/afc_pkg.sv =====
// Package for the ASTM frame checker: control characters, status codes,
// line-state and result structs, and the hex-digit decode helper.
// Used by every module of the block; depends on nothing.
package afc_pkg;

    // Control characters
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_ENQ = 8'h05;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ETB = 8'h17;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_F   = 8'h46;

    // Line limits
    localparam int unsigned COUNT_W   = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
    localparam logic [COUNT_W-1:0] MAX_LINE  = 9'd255;
    localparam logic [7:0] FLOOR_LEN   = 8'd5;
    localparam logic [7:0] MIN_LEN_RST = 8'd10;
    localparam logic [2:0] FRAME_NUM_RST = 3'd1;

    // Verdict codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_FRAMING   = 3'd2;
    localparam logic [2:0] ST_FRAME_NUM = 3'd3;
    localparam logic [2:0] ST_CHECKSUM  = 3'd4;
    localparam logic [2:0] ST_LONG      = 3'd5;

    // Stream widths
    localparam int unsigned OUT_DATA_W = 24;

    // Accumulated state of the line in progress; tail[0] is the oldest byte
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [7:0]         sum;
        logic [2:0][7:0]    head;
        logic [3:0][7:0]    tail;
    } t_line_state;

    // One verdict
    typedef struct packed {
        logic [2:0] status;
        logic       cont;
        logic [2:0] frame_num;
        logic [7:0] record_type;
        logic [7:0] frame_len;
    } t_result;

    // Decode a hex character, keeping the low nibble only
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_A && c <= CH_F) begin
            v = c - CH_A + 8'd10;
        end else begin
            v = c - CH_0;
        end
        return v[3:0];
    endfunction

endpackage

// ===== hdl/afc_line_acc.sv =====
// Line accumulator: byte count, running checksum, first three and last
// four bytes of the line in progress. Depends on afc_pkg.
module afc_line_acc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [7:0]           i_byte,
    output afc_pkg::t_line_state o_state
);

    afc_pkg::t_line_state r_state;
    afc_pkg::t_line_state n_state;

    // Work out the next line state for one byte
    always_comb begin
        n_state = r_state;
        if (i_en) begin
            if (i_byte == afc_pkg::CH_LF) begin
                n_state = '0;
            end else if (!(r_state.count == '0 && i_byte == afc_pkg::CH_ENQ)) begin
                if (r_state.count < 9'd3) begin
                    n_state.head[r_state.count[1:0]] = i_byte;
                end
                if (r_state.count != '0) begin
                    n_state.sum = r_state.sum + i_byte;
                end
                n_state.tail = {i_byte, r_state.tail[3:1]};
                if (r_state.count != afc_pkg::COUNT_MAX) begin
                    n_state.count = r_state.count + 9'd1;
                end
            end
        end
    end

    // Hold the line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// ===== hdl/afc_verdict.sv =====
// Verdict logic: judges a finished line against the minimum and maximum length, the
// framing rules, the expected frame number and the checksum. Depends on afc_pkg.
module afc_verdict #(
    parameter logic [afc_pkg::COUNT_W-1:0] MAX_LINE = afc_pkg::MAX_LINE
) (
    input  afc_pkg::t_line_state i_state,
    input  logic [7:0]           i_min_len,
    input  logic [2:0]           i_frame_num,
    output afc_pkg::t_result     o_result
);

    logic [7:0] min_len;
    logic [7:0] given;
    logic [7:0] calc;
    logic       framing_ok;

    assign min_len = (i_min_len < afc_pkg::FLOOR_LEN) ? afc_pkg::FLOOR_LEN : i_min_len;
    assign given   = {afc_pkg::hex_nibble(i_state.tail[1]),
                      afc_pkg::hex_nibble(i_state.tail[2])};
    assign calc    = i_state.sum - i_state.tail[1] - i_state.tail[2] - i_state.tail[3];
    assign framing_ok = (i_state.head[0] == afc_pkg::CH_STX)
                     && (i_state.tail[3] == afc_pkg::CH_CR)
                     && (i_state.tail[0] == afc_pkg::CH_ETX
                         || i_state.tail[0] == afc_pkg::CH_ETB);

    // Apply the checks in priority order
    always_comb begin
        priority if (i_state.count < {1'b0, min_len}) begin
            o_result.status = afc_pkg::ST_SHORT;
        end else if (i_state.count > MAX_LINE) begin
            o_result.status = afc_pkg::ST_LONG;
        end else if (!framing_ok) begin
            o_result.status = afc_pkg::ST_FRAMING;
        end else if (i_state.head[1] != ({5'd0, i_frame_num} + afc_pkg::CH_0)) begin
            o_result.status = afc_pkg::ST_FRAME_NUM;
        end else if (given != calc) begin
            o_result.status = afc_pkg::ST_CHECKSUM;
        end else begin
            o_result.status = afc_pkg::ST_OK;
        end
    end

    assign o_result.cont        = (i_state.count >= 9'd4)
                               && (i_state.tail[0] == afc_pkg::CH_ETB);
    assign o_result.frame_num   = i_frame_num;
    assign o_result.record_type = i_state.head[2];
    assign o_result.frame_len   = (i_state.count > 9'd255) ? 8'hFF : i_state.count[7:0];

endmodule

// ===== hdl/astm_frame_checker_unit.sv =====
// The LF byte passes the input register, then its verdict the result register.
// Throughput: one byte per cycle; non-LF bytes never wait on the master side,
// an LF byte waits only while a previous verdict is still held there.
// Reset (synchronous, active low) sets expected frame number 1, minimum length 10,
// clears the line state and drops both valid flags.
// Top level of the ASTM frame checker. Depends on afc_pkg, afc_line_acc, afc_verdict.
module astm_frame_checker_unit #(
    parameter logic [afc_pkg::COUNT_W-1:0] MAX_LINE = afc_pkg::MAX_LINE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [7:0]                      i_cfg_wdata,   // min_frame_length
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] frame_status, [5:3] frame_number, [13:6] record_type,
    // [21:14] frame_length, [23:22] zero
    output logic [afc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tuser   // continued
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic [7:0]           r_min_len;
    logic [2:0]           r_frame_num;
    logic                 r_out_valid;
    afc_pkg::t_result     r_out;
    afc_pkg::t_line_state line_state;
    afc_pkg::t_result     result;
    logic                 in_is_lf;
    logic                 out_free;
    logic                 proc_en;

    assign in_is_lf = (r_in_byte == afc_pkg::CH_LF);
    assign out_free = !r_out_valid || m_axis_tready;
    assign proc_en  = r_in_valid && (!in_is_lf || out_free);
    assign s_axis_tready = !r_in_valid || proc_en;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= afc_pkg::MIN_LEN_RST;
        end else if (i_cfg_we) begin
            r_min_len <= i_cfg_wdata;
        end
    end

    afc_line_acc u_line_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc_en),
        .i_byte  (r_in_byte),
        .o_state (line_state)
    );

    afc_verdict #(
        .MAX_LINE (MAX_LINE)
    ) u_verdict (
        .i_state     (line_state),
        .i_min_len   (r_min_len),
        .i_frame_num (r_frame_num),
        .o_result    (result)
    );

    // Expected frame number: reset on ENQ between lines, advance on a good frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_num <= afc_pkg::FRAME_NUM_RST;
        end else if (proc_en) begin
            if (in_is_lf) begin
                if (result.status == afc_pkg::ST_OK) begin
                    r_frame_num <= r_frame_num + 3'd1;
                end
            end else if (line_state.count == '0 && r_in_byte == afc_pkg::CH_ENQ) begin
                r_frame_num <= afc_pkg::FRAME_NUM_RST;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_en && in_is_lf) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_en && in_is_lf) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.frame_len, r_out.record_type,
                            r_out.frame_num, r_out.status};
    assign m_axis_tuser  = r_out.cont;

endmodule

// ===== hdl/afc_checker.sv =====
// Port-level checker for the ASTM frame checker, bound to the top level.
// Depends on afc_pkg and astm_frame_checker_unit.
module afc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [afc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);

    // No verdict survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("verdict valid right after reset");

    // Hold a stalled verdict
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled verdict changed");

    // Status code within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= afc_pkg::ST_LONG)
        else $error("undefined frame status");

    // A good frame is never below the length floor
    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == afc_pkg::ST_OK
            |-> m_axis_tdata[21:14] >= afc_pkg::FLOOR_LEN)
        else $error("good frame shorter than floor");

    // Continuation needs a terminator position inside the line
    a_cont_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[21:14] >= 8'd4)
        else $error("continued flag on a line shorter than four bytes");

endmodule

bind astm_frame_checker_unit afc_checker u_afc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb_astm_frame_checker_unit.sv =====
`timescale 1ns / 100ps
// Testbench for astm_frame_checker_unit: streams received bytes into the checker,
// predicts the verdict of every line and checks it on the output stream.
// Depends on afc_pkg and the checker RTL only.
module tb_astm_frame_checker_unit;

    // Ways to spoil an otherwise valid frame
    typedef enum int {
        FAULT_NONE,
        FAULT_STX,
        FAULT_CR,
        FAULT_TERM,
        FAULT_NUM,
        FAULT_SUM
    } fault_e;

    localparam int RX_HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_BYTES   = 120;
    localparam int END_WAIT_LIMIT = 2000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [7:0]                     i_cfg_wdata;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [afc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;

    // Line checker copy: expected frame number, line in progress, minimum length
    logic [2:0] exp_num;
    logic [8:0] ln_count;
    logic [7:0] ln_sum;
    logic [7:0] ln_head [0:2];
    logic [7:0] ln_tail [0:3];
    logic [7:0] min_len_cfg;

    afc_pkg::t_result verdict_q[$];
    afc_pkg::t_result verdict_want;
    logic [7:0]       line_buf[$];
    int               mismatch_count = 0;
    int               bytes_sent = 0;
    bit               tx_idle_en = 1'b1;
    bit               rx_idle_en = 1'b1;
    int               rx_hold_len = 0;

    astm_frame_checker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Decode one checksum character down to its low nibble
    function automatic logic [3:0] ascii_nibble(input logic [7:0] c);
        if (c >= afc_pkg::CH_A && c <= afc_pkg::CH_F) begin
            return c[3:0] + 4'd9;
        end
        return c[3:0];
    endfunction

    // Encode a nibble; the alternate form may use characters outside 0-9/A-F
    // that still decode to the same value
    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit alt_hex);
        if (alt_hex) begin
            return {($urandom_range(0, 1) ? 4'h5 : 4'h3), v};
        end
        if (v < 4'd10) begin
            return afc_pkg::CH_0 + v;
        end
        return afc_pkg::CH_A + v - 8'd10;
    endfunction

    // Any byte that does not end the line
    function automatic logic [7:0] line_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == afc_pkg::CH_LF);
        return b;
    endfunction

    // Replacement byte for a spoiled frame position
    function automatic logic [7:0] other_byte(input logic [7:0] avoid_a,
                                              input logic [7:0] avoid_b);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == avoid_a || b == avoid_b || b == afc_pkg::CH_LF || b == afc_pkg::CH_ENQ);
        return b;
    endfunction

    task automatic clear_line_state();
        ln_count = '0;
        ln_sum   = '0;
        for (int i = 0; i < 3; i++) ln_head[i] = '0;
        for (int i = 0; i < 4; i++) ln_tail[i] = '0;
    endtask

    // Add one byte at the end of the line being built
    task automatic buf_append(input logic [7:0] b);
        line_buf = {line_buf, b};
    endtask

    // Advance the line state by one accepted byte; queue a verdict at LF
    task automatic predict_byte(input logic [7:0] b);
        afc_pkg::t_result v;
        logic [7:0]       min_eff;
        logic [7:0]       given;
        logic [7:0]       calc;
        if (b != afc_pkg::CH_LF) begin
            if (ln_count == 0 && b == afc_pkg::CH_ENQ) begin
                exp_num = afc_pkg::FRAME_NUM_RST;
            end else begin
                if (ln_count < 3) ln_head[ln_count] = b;
                if (ln_count >= 1) ln_sum = ln_sum + b;
                ln_tail[0] = ln_tail[1];
                ln_tail[1] = ln_tail[2];
                ln_tail[2] = ln_tail[3];
                ln_tail[3] = b;
                if (ln_count < afc_pkg::COUNT_MAX) ln_count = ln_count + 1'b1;
            end
        end else begin
            min_eff       = (min_len_cfg < afc_pkg::FLOOR_LEN) ? afc_pkg::FLOOR_LEN
                                                               : min_len_cfg;
            v.cont        = (ln_count >= 4 && ln_tail[0] == afc_pkg::CH_ETB);
            v.frame_num   = exp_num;
            v.record_type = ln_head[2];
            v.frame_len   = (ln_count > 9'd255) ? 8'hFF : ln_count[7:0];
            if (ln_count < min_eff) begin
                v.status = afc_pkg::ST_SHORT;
            end else if (ln_count > afc_pkg::MAX_LINE) begin
                v.status = afc_pkg::ST_LONG;
            end else if (ln_head[0] != afc_pkg::CH_STX || ln_tail[3] != afc_pkg::CH_CR ||
                         (ln_tail[0] != afc_pkg::CH_ETX &&
                          ln_tail[0] != afc_pkg::CH_ETB)) begin
                v.status = afc_pkg::ST_FRAMING;
            end else if (ln_head[1] != afc_pkg::CH_0 + exp_num) begin
                v.status = afc_pkg::ST_FRAME_NUM;
            end else begin
                // sum runs from the frame number through the terminator
                given    = {ascii_nibble(ln_tail[1]), ascii_nibble(ln_tail[2])};
                calc     = ln_sum - ln_tail[1] - ln_tail[2] - ln_tail[3];
                v.status = (given == calc) ? afc_pkg::ST_OK : afc_pkg::ST_CHECKSUM;
            end
            verdict_q = {verdict_q, v};
            if (v.status == afc_pkg::ST_OK) exp_num = exp_num + 1'b1;
            clear_line_state();
        end
    endtask

    // Offer one byte after a random gap and hold it until the transaction
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk);
        while (!s_axis_tready);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_byte(line_buf[i]);
        send_byte(afc_pkg::CH_LF);
    endtask

    task automatic fill_noise(input int len);
        line_buf.delete();
        repeat (len) buf_append(line_byte());
    endtask

    // Build STX, number, record type, body, terminator, checksum, CR
    task automatic build_frame(input logic [7:0] rec, input int body_len,
                               input logic [7:0] term, input fault_e fault, input bit alt_hex);
        logic [7:0] digit;
        logic [7:0] chk_sum;
        logic [7:0] b;
        logic [2:0] wrong_num;
        wrong_num = exp_num + 3'($urandom_range(1, 7));
        digit     = (fault == FAULT_NUM) ? afc_pkg::CH_0 + wrong_num : afc_pkg::CH_0 + exp_num;
        line_buf.delete();
        buf_append(afc_pkg::CH_STX);
        buf_append(digit);
        buf_append(rec);
        chk_sum = digit + rec;
        for (int i = 1; i < body_len; i++) begin
            b = line_byte();
            buf_append(b);
            chk_sum = chk_sum + b;
        end
        buf_append(term);
        chk_sum = chk_sum + term;
        if (fault == FAULT_SUM) chk_sum = chk_sum + 8'($urandom_range(1, 255));
        buf_append(hex_char(chk_sum[7:4], alt_hex));
        buf_append(hex_char(chk_sum[3:0], alt_hex));
        buf_append(afc_pkg::CH_CR);
        case (fault)
            FAULT_STX:  line_buf[0] = other_byte(afc_pkg::CH_STX, afc_pkg::CH_STX);
            FAULT_CR:   line_buf[line_buf.size()-1] = other_byte(afc_pkg::CH_CR, afc_pkg::CH_CR);
            FAULT_TERM: line_buf[line_buf.size()-4] = other_byte(afc_pkg::CH_ETX,
                                                                 afc_pkg::CH_ETB);
            default: ;
        endcase
    endtask

    // Stop offering and wait until every verdict is out
    task automatic drain_verdicts();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_len(input logic [7:0] v);
        drain_verdicts();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        min_len_cfg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Reset values: empty lines, short lines, the shortest accepted length
    task automatic test_defaults();
        fill_noise(0);
        send_line();
        line_buf = '{afc_pkg::CH_STX, afc_pkg::CH_0 + exp_num, "R", afc_pkg::CH_ETX};
        send_line();
        build_frame("H", 4, afc_pkg::CH_ETX, FAULT_NONE, 1'b0);
        send_line();
        build_frame("P", 3, afc_pkg::CH_ETX, FAULT_NONE, 1'b0);
        send_line();
    endtask

    // Each framing fault, continuation, frame number and checksum errors
    task automatic test_framing();
        build_frame("O", 5, afc_pkg::CH_ETX, FAULT_STX, 1'b0);
        send_line();
        build_frame("O", 5, afc_pkg::CH_ETX, FAULT_CR, 1'b0);
        send_line();
        build_frame("O", 5, afc_pkg::CH_ETB, FAULT_TERM, 1'b0);
        send_line();
        build_frame("R", 6, afc_pkg::CH_ETB, FAULT_NONE, 1'b0);
        send_line();
        build_frame("R", 6, afc_pkg::CH_ETX, FAULT_NUM, 1'b0);
        send_line();
        build_frame("R", 6, afc_pkg::CH_ETB, FAULT_SUM, 1'b0);
        send_line();
        build_frame("C", 7, afc_pkg::CH_ETX, FAULT_NONE, 1'b1);
        send_line();
    endtask

    // Wrap the frame number past 7, then reset it with ENQ between lines
    task automatic test_frame_number();
        repeat (8) begin
            build_frame("R", 4, afc_pkg::CH_ETX, FAULT_NONE, 1'b0);
            send_line();
        end
        send_byte(afc_pkg::CH_ENQ);
        // ENQ inside a line is an ordinary byte, here the record type
        build_frame(afc_pkg::CH_ENQ, 4, afc_pkg::CH_ETX, FAULT_NONE, 1'b0);
        send_line();
        send_byte(afc_pkg::CH_ENQ);
        send_byte(afc_pkg::CH_LF);
    endtask

    // Minimum length below the floor and at the floor
    task automatic test_min_length();
        write_min_len(8'd0);
        line_buf = '{afc_pkg::CH_STX, afc_pkg::CH_0 + exp_num, "R", afc_pkg::CH_ETX};
        send_line();
        line_buf = '{afc_pkg::CH_STX, afc_pkg::CH_0 + exp_num, "R", afc_pkg::CH_ETX,
                     afc_pkg::CH_CR};
        send_line();
        build_frame("L", 1, afc_pkg::CH_ETX, FAULT_NONE, 1'b0);
        send_line();
        write_min_len(8'd4);
        line_buf = '{afc_pkg::CH_STX, afc_pkg::CH_0 + exp_num, "R", afc_pkg::CH_ETX,
                     afc_pkg::CH_CR};
        send_line();
        write_min_len(afc_pkg::FLOOR_LEN);
        build_frame("L", 1, afc_pkg::CH_ETB, FAULT_NONE, 1'b0);
        send_line();
        write_min_len(afc_pkg::MIN_LEN_RST);
    endtask

    // A well-formed frame one byte past the maximum line length
    task automatic test_long_lines();
        build_frame("R", 250, afc_pkg::CH_ETX, FAULT_NONE, 1'b0);
        send_line();
    endtask

    // Hold the receiver off while short lines keep coming, so the input stalls
    task automatic test_backpressure();
        drain_verdicts();
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        rx_hold_len = RX_HOLD_CYCLES;
        repeat (12) begin
            fill_noise($urandom_range(0, 3));
            send_line();
        end
        drain_verdicts();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Mostly valid frames with random content; faults, noise, ENQs and
    // reconfiguration mixed in
    task automatic test_random_traffic();
        int         start_bytes;
        int         pick;
        int         body_len;
        fault_e     fault;
        logic [7:0] rec;
        logic [7:0] term;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                fault    = (pick >= 60 && pick < 72) ? fault_e'($urandom_range(1, 5)) : FAULT_NONE;
                body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                       : $urandom_range(1, 12);
                term     = $urandom_range(0, 1) ? afc_pkg::CH_ETB : afc_pkg::CH_ETX;
                rec      = ($urandom_range(0, 3) == 0) ? line_byte()
                                                       : afc_pkg::CH_A + 8'($urandom_range(0, 25));
                if (pick >= 72) send_byte(afc_pkg::CH_ENQ);
                build_frame(rec, body_len, term, fault, $urandom_range(0, 3) == 0);
                send_line();
            end else if (pick < 88) begin
                fill_noise($urandom_range(0, 16));
                if (line_buf.size() != 0 && $urandom_range(0, 1)) line_buf[0] = afc_pkg::CH_STX;
                send_line();
            end else if (pick < 94) begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end else if (pick < 97) begin
                write_min_len(8'($urandom_range(0, 16)));
            end else begin
                send_byte(afc_pkg::CH_ENQ);
            end
        end
    endtask

    // Compare each verdict transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t ns: verdict with none pending: expected none, actual data %h user %b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                verdict_want = verdict_q.pop_front();
                check_field("frame_status", verdict_want.status, m_axis_tdata[2:0]);
                check_field("frame_number", verdict_want.frame_num, m_axis_tdata[5:3]);
                check_field("record_type", verdict_want.record_type, m_axis_tdata[13:6]);
                check_field("frame_length", verdict_want.frame_len, m_axis_tdata[21:14]);
                check_field("continued", verdict_want.cont, m_axis_tuser);
            end
        end
    end

    // Receiver: random stall before each transaction, long hold-off on request
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            if (rx_hold_len > 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
            end
            stall = rx_idle_en ? $urandom_range(0, 8) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready) && rx_hold_len == 0);
        end
    end

    // Sequence the tests and decide the outcome
    initial begin
        int end_wait;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        exp_num       = afc_pkg::FRAME_NUM_RST;
        min_len_cfg   = afc_pkg::MIN_LEN_RST;
        clear_line_state();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_framing();
        test_frame_number();
        test_min_length();
        test_long_lines();
        test_backpressure();
        test_random_traffic();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        end_wait = 0;
        while (verdict_q.size() != 0 && end_wait < END_WAIT_LIMIT) begin
            @(posedge i_clk);
            end_wait++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            $display("%0t ns: missing verdicts: expected %0d more, actual 0",
                     $time, verdict_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
